### rtl/u2f_pkg.sv
// shared types and constants for the u2f hid message reassembler
`timescale 1ns / 1ps

package u2f_pkg;

	localparam logic [6:0] REPORT_BYTES     = 7'd64;
	localparam logic [5:0] INIT_PAYLOAD     = 6'd57;
	localparam logic [5:0] CONT_PAYLOAD     = 6'd59;
	localparam logic [6:0] REPORT_COUNT_MAX = 7'd127;

	localparam logic [6:0] ID_LAST_IDX = 7'd3;
	localparam logic [6:0] CMD_IDX     = 7'd4;
	localparam logic [6:0] LEN_HI_IDX  = 7'd5;
	localparam logic [6:0] LEN_LO_IDX  = 7'd6;

	localparam int unsigned TDATA_W = 80;
	localparam int unsigned TUSER_W = 3;

	typedef struct packed {
		logic        report_rejected;
		logic        message_complete;
		logic        payload_valid;
		logic        report_done;
		logic [15:0] message_length;
		logic [7:0]  command;
		logic [31:0] channel_id;
		logic [7:0]  payload_byte;
		logic [15:0] payload_offset;
	} result_t;

endpackage

### rtl/u2f_hdr_core.sv
// per-byte header decode, report framing and message byte counting
`timescale 1ns / 1ps

module u2f_hdr_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [31:0]     cfg_data,
	input  logic            accept,
	input  logic [7:0]      data_byte,
	input  logic            last,
	output u2f_pkg::result_t res
);

	logic [31:0] reserved_q;
	logic [6:0]  report_count_q, n_count;
	logic [5:0]  byte_position_q, n_pos;
	logic [31:0] id_shift_q, n_id, id_next;
	logic        is_initial_q, n_init;
	logic        rejecting_q, n_rej;
	logic [7:0]  length_high_q, n_lenhi;
	logic [15:0] total_length_q, n_total;
	logic [15:0] received_count_q, n_recv;
	logic [31:0] stored_channel_q, n_chan;
	logic [7:0]  stored_command_q, n_cmd;
	logic [5:0]  limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else if (cfg_we) begin
			reserved_q <= cfg_data;
		end
	end

	always_comb begin
		n_count = report_count_q;
		n_pos   = byte_position_q;
		n_id    = id_shift_q;
		n_init  = is_initial_q;
		n_rej   = rejecting_q;
		n_lenhi = length_high_q;
		n_total = total_length_q;
		n_recv  = received_count_q;
		n_chan  = stored_channel_q;
		n_cmd   = stored_command_q;
		id_next = {id_shift_q[23:0], data_byte};
		limit   = is_initial_q ? u2f_pkg::INIT_PAYLOAD : u2f_pkg::CONT_PAYLOAD;
		res     = '0;

		if (report_count_q < u2f_pkg::REPORT_BYTES && !rejecting_q) begin
			if (report_count_q < u2f_pkg::CMD_IDX) begin
				n_id = id_next;
				if (report_count_q == u2f_pkg::ID_LAST_IDX && id_next == reserved_q) begin
					n_rej = 1'b1;
				end
			end else if (report_count_q == u2f_pkg::CMD_IDX) begin
				if (data_byte[7]) begin
					n_init  = 1'b1;
					n_chan  = id_shift_q;
					n_cmd   = data_byte;
					n_total = '0;
					n_recv  = '0;
				end
			end else if (is_initial_q && report_count_q == u2f_pkg::LEN_HI_IDX) begin
				n_lenhi = data_byte;
			end else if (is_initial_q && report_count_q == u2f_pkg::LEN_LO_IDX) begin
				n_total = {length_high_q, data_byte};
			end else if (byte_position_q < limit && received_count_q < total_length_q) begin
				res.payload_valid  = 1'b1;
				res.payload_offset = received_count_q;
				res.payload_byte   = data_byte;
				n_recv             = received_count_q + 16'd1;
				n_pos              = byte_position_q + 6'd1;
			end
		end

		if (report_count_q != u2f_pkg::REPORT_COUNT_MAX) begin
			n_count = report_count_q + 7'd1;
		end

		res.report_done = last;
		if (last) begin
			res.report_rejected  = n_rej;
			res.message_complete = !n_rej && (n_recv == n_total);
			n_count = '0;
			n_pos   = '0;
			n_id    = '0;
			n_init  = 1'b0;
			n_rej   = 1'b0;
			n_lenhi = '0;
		end

		res.channel_id     = n_chan;
		res.command        = n_cmd;
		res.message_length = n_total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_count_q   <= '0;
			byte_position_q  <= '0;
			id_shift_q       <= '0;
			is_initial_q     <= 1'b0;
			rejecting_q      <= 1'b0;
			length_high_q    <= '0;
			total_length_q   <= '0;
			received_count_q <= '0;
			stored_channel_q <= '0;
			stored_command_q <= '0;
		end else if (accept) begin
			report_count_q   <= n_count;
			byte_position_q  <= n_pos;
			id_shift_q       <= n_id;
			is_initial_q     <= n_init;
			rejecting_q      <= n_rej;
			length_high_q    <= n_lenhi;
			total_length_q   <= n_total;
			received_count_q <= n_recv;
			stored_channel_q <= n_chan;
			stored_command_q <= n_cmd;
		end
	end

`ifndef SYNTHESIS
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last && rejecting_q |=> rejecting_q)
		else $error("rejecting dropped inside a report");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> report_count_q == '0 && byte_position_q == '0 && !rejecting_q)
		else $error("per-report state not cleared at report end");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.payload_valid |=>
		received_count_q == 16'($past(received_count_q) + 16'd1))
		else $error("received count did not advance with a payload byte");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_position_q <= u2f_pkg::CONT_PAYLOAD)
		else $error("byte position beyond report payload");
`endif

endmodule

### rtl/u2f_out_reg.sv
// result register toward the master side stream
`timescale 1ns / 1ps

module u2f_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  u2f_pkg::result_t              res,
	output logic                          space,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [u2f_pkg::TDATA_W-1:0]   m_axis_tdata,
	output logic [u2f_pkg::TUSER_W-1:0]   m_axis_tuser,
	output logic                          m_axis_tlast
);

	logic             valid_q;
	u2f_pkg::result_t res_q;

	assign space = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {res_q.message_length, res_q.command, res_q.channel_id,
		res_q.payload_byte, res_q.payload_offset};
	assign m_axis_tuser  = {res_q.report_rejected, res_q.message_complete, res_q.payload_valid};
	assign m_axis_tlast  = res_q.report_done;

`ifndef SYNTHESIS
	a_load_needs_space: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> space)
		else $error("result loaded while register full");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> valid_q)
		else $error("loaded beat not presented");

	a_idle_drains: assert property (@(posedge clk) disable iff (!arst_n)
		!load && space |=> !valid_q)
		else $error("beat presented without a load");
`endif

endmodule

### rtl/u2f_hid_message_reassembler.sv
// top level of the u2f hid message reassembler
`timescale 1ns / 1ps

// Takes raw hid report bytes, one beat per byte, and returns one result beat
// per byte: a payload byte with its message offset when the byte belongs to the
// message, the latched channel id, command and announced length, and at the
// end of a report the completion and rejection flags. One byte is taken every
// cycle while the output register has space; a result appears in the cycle after
// its byte is taken, from a single output register. s_axis_tready is high
// whenever that register is empty or being read out, so the input only stalls
// when the master side stalls. The user must write the reserved channel register
// through cfg_* only while no byte is in flight; the block does not enforce it.
module u2f_hid_message_reassembler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [31:0]                  cfg_data,      // reserved_channel
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // data_byte
	input  logic                         s_axis_tlast,  // last_in_report
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// payload_offset, payload_byte, channel_id, command, message_length
	output logic [u2f_pkg::TDATA_W-1:0]  m_axis_tdata,
	// payload_valid, message_complete, report_rejected
	output logic [u2f_pkg::TUSER_W-1:0]  m_axis_tuser,
	output logic                         m_axis_tlast   // report_done
);

	logic             space;
	logic             accept;
	u2f_pkg::result_t res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = space;
	assign accept        = s_axis_tvalid && space;

	u2f_hdr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.data_byte (s_axis_tdata),
		.last      (s_axis_tlast),
		.res       (res)
	);

	u2f_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.res           (res),
		.space         (space),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
